>>> hw/rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by lkv_tag_array and lru_key_value_cache; no dependencies.
package lkv_pkg;

    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 7;
    localparam int MAX_ENTRIES_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET  = 7'd64;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // request kinds
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] write_value;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } t_rsp;

endpackage

>>> hw/rtl/lkv_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/lkv_tag_array.sv
// Key CAM with per-entry recency ranks and occupancy for the LRU cache.
// Depends on lkv_pkg for key and capacity widths.
module lkv_tag_array #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic [lkv_pkg::CAP_W-1:0]     i_capacity,
    input  logic                          i_op_en,
    input  logic                          i_op_put,
    input  logic [lkv_pkg::KEY_W-1:0]     i_key,
    output logic                          o_hit,
    output logic [IDX_W-1:0]              o_slot
);

    localparam int RANK_W = IDX_W;
    localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CW     = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;

    logic                          r_valid [MAX_ENTRIES];
    logic [lkv_pkg::KEY_W-1:0]     r_key   [MAX_ENTRIES];
    logic [RANK_W-1:0]             r_rank  [MAX_ENTRIES];
    logic [OCC_W-1:0]              r_occ;

    logic [MAX_ENTRIES-1:0] match;
    logic [MAX_ENTRIES-1:0] victim;
    logic [RANK_W-1:0]      hit_rank;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       ins_idx;
    logic [CW-1:0]          eff_cap;
    logic [OCC_W-1:0]       occ_m1;
    logic                   full;

    always_comb begin
        logic [CW-1:0] cap_x;
        cap_x = CW'(i_capacity);
        if (cap_x == '0) begin
            eff_cap = CW'(1);
        end else if (cap_x > CW'(MAX_ENTRIES)) begin
            eff_cap = CW'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_x;
        end
    end

    assign full   = CW'(r_occ) >= eff_cap;
    assign occ_m1 = r_occ - 1'b1;

    // the oldest valid entry always carries rank occupancy-1
    always_comb begin
        hit_rank = '0;
        hit_idx  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_key[i] == i_key);
            victim[i] = full && r_valid[i] && (r_rank[i] == occ_m1[RANK_W-1:0]);
            if (match[i]) begin
                hit_rank = hit_rank | r_rank[i];
                hit_idx  = hit_idx | IDX_W'(i);
            end
        end
    end

    // lowest free slot, counting the evicted one as free
    always_comb begin
        ins_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i] || victim[i]) begin
                ins_idx = IDX_W'(i);
            end
        end
    end

    assign o_hit  = |match;
    assign o_slot = o_hit ? hit_idx : ins_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= '0;
            end
            r_occ <= '0;
        end else if (i_op_en) begin
            if (o_hit) begin
                // promote the hit entry, age the ones that were more recent
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (match[i]) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
            end else if (i_op_put) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (IDX_W'(i) == ins_idx) begin
                        r_valid[i] <= 1'b1;
                        r_rank[i]  <= '0;
                    end else if (victim[i]) begin
                        r_valid[i] <= 1'b0;
                        r_rank[i]  <= '0;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                if (!full) begin
                    r_occ <= r_occ + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op_en && i_op_put && !o_hit) begin
            r_key[ins_idx] <= i_key;
        end
    end

endmodule

>>> hw/rtl/lru_key_value_cache.sv
// LRU key-value cache top level: request/response pipeline around the tag array and value RAM.
// Depends on lkv_pkg, lkv_tag_array and lkv_ram.
//
// Usage:
//   Request channel (i_req_valid / o_req_ready, payload i_req) carries gets and puts.
//   Response channel (o_rsp_valid / i_rsp_ready, payload o_rsp) returns one response
//   per get: hit flag and stored value, or all ones on a miss. Puts return nothing.
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data) writes the capacity;
//   it is always ready and every write empties the cache. Write it only when idle.
// Timing:
//   A request is registered on acceptance, then looked up and applied against the key CAM
//   while the value RAM is read or written; a get's response passes through the RAM read
//   stage and the output register. One request per cycle is sustained while responses are
//   taken, set by the CAM compare and rank update and the one RAM port pair.
// Reset:
//   Synchronous, active low. Empties the cache and sets capacity to 64.
// Stalls:
//   A held response stalls the lookup stage only when a get must move into the RAM
//   read stage; puts keep draining. Ready goes low once the pipeline is full.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  lkv_pkg::t_req                 i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output lkv_pkg::t_rsp                 o_rsp,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [lkv_pkg::CAP_W-1:0] r_capacity;
    logic                      r_a_vld;
    lkv_pkg::t_req             r_a_req;
    logic                      r_b_vld;
    logic                      r_b_hit;
    logic                      r_o_vld;
    lkv_pkg::t_rsp             r_o_rsp;

    logic                      cfg_wr;
    logic                      out_free;
    logic                      b_free;
    logic                      a_put;
    logic                      a_done;
    logic                      lk_hit;
    logic [IDX_W-1:0]          lk_slot;
    logic [lkv_pkg::VAL_W-1:0] ram_q;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    assign out_free    = !r_o_vld || i_rsp_ready;
    assign b_free      = !r_b_vld || out_free;
    assign a_put       = (r_a_req.req_type == lkv_pkg::REQ_PUT);
    // puts retire in the lookup stage; gets need room in the read stage
    assign a_done      = r_a_vld && (a_put || b_free);
    assign o_req_ready = !r_a_vld || a_done;

    lkv_tag_array #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_tags (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_wr),
        .i_capacity (r_capacity),
        .i_op_en    (a_done),
        .i_op_put   (a_put),
        .i_key      (r_a_req.lookup_key),
        .o_hit      (lk_hit),
        .o_slot     (lk_slot)
    );

    lkv_ram #(
        .WIDTH (lkv_pkg::VAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (a_done && a_put),
        .i_waddr (lk_slot),
        .i_wdata (r_a_req.write_value),
        .i_re    (a_done && !a_put && lk_hit),
        .i_raddr (lk_slot),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkv_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_a_vld <= i_req_valid;
            end
            if (a_done && !a_put) begin
                r_b_vld <= 1'b1;
            end else if (r_b_vld && out_free) begin
                r_b_vld <= 1'b0;
            end
            if (r_b_vld && out_free) begin
                r_o_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_a_req <= i_req;
        end
        if (a_done && !a_put) begin
            r_b_hit <= lk_hit;
        end
        if (r_b_vld && out_free) begin
            r_o_rsp.hit        <= r_b_hit;
            r_o_rsp.read_value <= r_b_hit ? ram_q : lkv_pkg::MISS_VALUE;
        end
    end

    assign o_rsp_valid = r_o_vld;
    assign o_rsp       = r_o_rsp;

    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !r_o_rsp.hit) |-> (r_o_rsp.read_value == lkv_pkg::MISS_VALUE))
        else $error("miss response without all-ones value");

    a_read_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && !out_free) |=> r_b_vld)
        else $error("read stage dropped a stalled get");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_req_ready |-> (r_a_vld && !a_put && r_b_vld && r_o_vld))
        else $error("request ready low with room in the pipeline");

endmodule

>>> tb/lru_key_value_cache_test.sv
// Self-checking testbench for lru_key_value_cache: directed table, then random gets and puts
// under several capacities, checked against a behavioral LRU cache model kept in the bench.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 1ps

module lru_key_value_cache_test;

    localparam int          SLOTS         = lkv_pkg::MAX_ENTRIES_DEF;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD     = 90;
    localparam int          PHASE_ITEMS   = 113;
    localparam int          HOLD_PHASE    = 1;
    localparam int          PAUSE_PHASE   = 2;
    localparam int          PRINT_LIMIT   = 100;
    localparam int unsigned CYCLE_LIMIT   = 500000;

    typedef struct {
        bit                        cfg_write;
        logic [lkv_pkg::CAP_W-1:0] cap;
        lkv_pkg::t_req             req;
        bit                        typed;
        lkv_pkg::t_rsp             want;
    } t_row;

    logic                      i_clk;
    logic                      rst_n      = 1'b0;
    logic                      req_valid  = 1'b0;
    lkv_pkg::t_req             req_bus    = '0;
    logic                      rsp_ready  = 1'b0;
    logic                      cfg_valid  = 1'b0;
    logic [lkv_pkg::CAP_W-1:0] cfg_data   = '0;
    logic                      o_req_ready;
    logic                      o_rsp_valid;
    lkv_pkg::t_rsp             o_rsp;
    logic                      o_cfg_ready;

    // bench copy of the cache contents
    logic                      slot_valid [SLOTS];
    logic [lkv_pkg::KEY_W-1:0] slot_key   [SLOTS];
    logic [lkv_pkg::VAL_W-1:0] slot_val   [SLOTS];
    int unsigned               slot_age   [SLOTS];
    int unsigned               fill;
    logic [lkv_pkg::CAP_W-1:0] cap_reg;

    lkv_pkg::t_rsp             lookups_due [$];
    lkv_pkg::t_rsp             rsp_want;
    t_row                      dir_rows [$];
    logic [lkv_pkg::KEY_W-1:0] key_pool [$];
    int unsigned               mismatch_count = 0;
    int unsigned               cycle_count    = 0;
    bit                        quiet          = 1'b0;
    bit                        hold_rsp       = 1'b0;

    lru_key_value_cache #(
        .MAX_ENTRIES(SLOTS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (req_bus),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(rsp_ready),
        .o_rsp      (o_rsp),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void cache_clear();
        for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_val[i]   = '0;
            slot_age[i]   = 0;
        end
        fill = 0;
    endfunction

    function automatic int unsigned usable_slots(logic [lkv_pkg::CAP_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > SLOTS)
            return SLOTS;
        return 32'(c);
    endfunction

    // entries younger than the touched one age by one
    function automatic void promote(int slot);
        int unsigned age_of;
        age_of = slot_age[slot];
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_age[i] < age_of)
                slot_age[i]++;
        slot_age[slot] = 0;
    endfunction

    // apply one request to the bench cache; returns 1 when it yields a response
    function automatic bit cache_access(input lkv_pkg::t_req r, output lkv_pkg::t_rsp rsp);
        int                        hit_slot;
        int                        victim;
        int                        free_slot;
        logic [lkv_pkg::KEY_W-1:0] key;
        key       = r.lookup_key;
        hit_slot  = -1;
        victim    = -1;
        free_slot = -1;
        rsp.hit        = 1'b0;
        rsp.read_value = lkv_pkg::MISS_VALUE;
        for (int i = 0; i < SLOTS; i++)
            if (hit_slot < 0 && slot_valid[i] && slot_key[i] == key)
                hit_slot = i;

        if (r.req_type == lkv_pkg::REQ_GET) begin
            if (hit_slot >= 0) begin
                rsp.hit        = 1'b1;
                rsp.read_value = slot_val[hit_slot];
                promote(hit_slot);
            end
            return 1'b1;
        end

        if (hit_slot >= 0) begin
            slot_val[hit_slot] = r.write_value;
            promote(hit_slot);
            return 1'b0;
        end

        if (fill >= usable_slots(cap_reg)) begin
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                    victim = i;
            if (victim >= 0) begin
                slot_valid[victim] = 1'b0;
                slot_age[victim]   = 0;
                fill--;
            end
        end

        for (int i = 0; i < SLOTS; i++)
            if (free_slot < 0 && !slot_valid[i])
                free_slot = i;
        if (free_slot >= 0) begin
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i])
                    slot_age[i]++;
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = key;
            slot_val[free_slot]   = r.write_value;
            slot_age[free_slot]   = 0;
            fill++;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic t_row put_row(logic [lkv_pkg::KEY_W-1:0] k,
                                     logic [lkv_pkg::VAL_W-1:0] v);
        t_row row;
        row           = '{default: '0};
        row.req       = '{req_type: lkv_pkg::REQ_PUT, lookup_key: k, write_value: v};
        return row;
    endfunction

    // typed = 1 carries a hand-written expectation
    function automatic t_row get_row(logic [lkv_pkg::KEY_W-1:0] k, bit typed, logic h,
                                     logic [lkv_pkg::VAL_W-1:0] v);
        t_row row;
        row       = '{default: '0};
        row.req   = '{req_type: lkv_pkg::REQ_GET, lookup_key: k, write_value: $urandom};
        row.typed = typed;
        row.want  = '{hit: h, read_value: v};
        return row;
    endfunction

    function automatic t_row cap_row(logic [lkv_pkg::CAP_W-1:0] c);
        t_row row;
        row           = '{default: '0};
        row.cfg_write = 1'b1;
        row.cap       = c;
        return row;
    endfunction

    // offer one request and hold it until accepted, then predict
    task automatic send_req(input lkv_pkg::t_req r, input bit typed,
                            input lkv_pkg::t_rsp typed_rsp);
        lkv_pkg::t_rsp pred;
        req_valid <= 1'b1;
        req_bus   <= r;
        do @(posedge i_clk); while (!o_req_ready);
        if (cache_access(r, pred))
            lookups_due.push_back(typed ? typed_rsp : pred);
    endtask

    task automatic idle_sender(input int n);
        req_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // drop valid, wait out every pending response and the trailing puts
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (lookups_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] c);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        cap_reg = c;
        cache_clear();
    endtask

    function automatic lkv_pkg::t_req pick_req();
        lkv_pkg::t_req r;
        r.req_type    = ($urandom_range(0, 99) < 55) ? lkv_pkg::REQ_PUT : lkv_pkg::REQ_GET;
        r.lookup_key  = ($urandom_range(0, 99) < 85) ?
                        key_pool[$urandom_range(0, key_pool.size() - 1)] : $urandom;
        r.write_value = $urandom;
        return r;
    endfunction

    // response side: random stalls, one long hold on request
    initial begin
        int n;
        forever begin
            if (hold_rsp) begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_rsp = 1'b0;
            end else if (!quiet && $urandom_range(0, 9) < 3) begin
                rsp_ready <= 1'b0;
                n = $urandom_range(1, 14);
                repeat (n) @(posedge i_clk);
            end else begin
                rsp_ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && o_rsp_valid && rsp_ready) begin
            if (lookups_due.size() == 0) begin
                report_mismatch("response with none pending", o_rsp.read_value, '0);
            end else begin
                rsp_want = lookups_due.pop_front();
                if (o_rsp.hit !== rsp_want.hit)
                    report_mismatch("hit", 32'(o_rsp.hit), 32'(rsp_want.hit));
                if (o_rsp.read_value !== rsp_want.read_value)
                    report_mismatch("read_value", o_rsp.read_value, rsp_want.read_value);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [lkv_pkg::CAP_W-1:0] phase_caps [11];
        int unsigned               pool_n;

        phase_caps = '{7'd127, 7'd64, 7'd16, 7'd1, 7'd2, 7'd3, 7'd8, 7'd31, 7'd0,
                       7'd100, 7'd64};
        cap_reg = lkv_pkg::CAP_RESET;
        cache_clear();

        dir_rows.push_back(get_row(32'h0000_0000, 1, 1'b0, lkv_pkg::MISS_VALUE));
        dir_rows.push_back(put_row(32'h7FFF_FFFF, 32'h8000_0000));
        dir_rows.push_back(get_row(32'h7FFF_FFFF, 1, 1'b1, 32'h8000_0000));
        dir_rows.push_back(put_row(32'h8000_0000, 32'h7FFF_FFFF));
        dir_rows.push_back(get_row(32'h8000_0000, 1, 1'b1, 32'h7FFF_FFFF));
        dir_rows.push_back(put_row(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        dir_rows.push_back(get_row(32'hFFFF_FFFF, 1, 1'b1, 32'hFFFF_FFFF));
        dir_rows.push_back(put_row(32'h0000_0000, 32'h0000_0000));
        dir_rows.push_back(get_row(32'h0000_0000, 1, 1'b1, 32'h0000_0000));
        // replace in place, no eviction
        dir_rows.push_back(put_row(32'h7FFF_FFFF, 32'h0000_0005));
        dir_rows.push_back(get_row(32'h7FFF_FFFF, 0, 1'b0, '0));
        // zero capacity behaves as one entry; the write also empties the store
        dir_rows.push_back(cap_row(7'd0));
        dir_rows.push_back(get_row(32'h0000_0000, 1, 1'b0, lkv_pkg::MISS_VALUE));
        dir_rows.push_back(put_row(32'h0000_0001, 32'h0000_0011));
        dir_rows.push_back(put_row(32'h0000_0002, 32'h0000_0022));
        dir_rows.push_back(get_row(32'h0000_0001, 0, 1'b0, '0));
        dir_rows.push_back(get_row(32'h0000_0002, 0, 1'b0, '0));
        // a hit refreshes recency, so the other entry is the victim
        dir_rows.push_back(cap_row(7'd2));
        dir_rows.push_back(put_row(32'h0000_0001, 32'h0000_00AA));
        dir_rows.push_back(put_row(32'h0000_0002, 32'h0000_00BB));
        dir_rows.push_back(get_row(32'h0000_0001, 0, 1'b0, '0));
        dir_rows.push_back(put_row(32'h0000_0003, 32'h0000_00CC));
        dir_rows.push_back(get_row(32'h0000_0002, 0, 1'b0, '0));
        dir_rows.push_back(get_row(32'h0000_0001, 0, 1'b0, '0));
        dir_rows.push_back(get_row(32'h0000_0003, 0, 1'b0, '0));

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_write) begin
                settle();
                write_capacity(dir_rows[i].cap);
            end else begin
                send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        foreach (phase_caps[p]) begin
            settle();
            if (p == $size(phase_caps) - 1)
                quiet = 1'b1;
            write_capacity(phase_caps[p]);

            // a pool a bit larger than the capacity keeps hits and evictions both common
            pool_n = usable_slots(phase_caps[p]);
            pool_n = pool_n + pool_n / 2 + 2;
            key_pool.delete();
            repeat (pool_n) key_pool.push_back($urandom);
            key_pool.push_back(32'h8000_0000);
            key_pool.push_back(32'h7FFF_FFFF);

            if (p == HOLD_PHASE)
                hold_rsp = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
                    req_valid <= 1'b0;
                    @(posedge i_clk);
                    while (lookups_due.size() != 0)
                        @(posedge i_clk);
                end else if (!quiet && $urandom_range(0, 99) < 15) begin
                    idle_sender($urandom_range(1, 14));
                end
                send_req(pick_req(), 1'b0, '0);
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
